// ===== rtl/core/slc_pkg.sv =====
// Shared constants, types and widths for the signed log compander.
package slc_pkg;

    // Sample and gain formats
    localparam int SAMPLE_WIDTH  = 16;
    localparam int LOG_FRAC_BITS = 16;
    localparam int GAIN_W        = 16;
    localparam int GAIN_FRAC     = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;

    // log2 datapath: exponent, Q1.30 mantissa, Q.LOG_FRAC_BITS result
    localparam int E_W    = $clog2(SAMPLE_WIDTH);
    localparam int Y_W    = 31;
    localparam int LOG2_W = E_W + LOG_FRAC_BITS;

    // ln(2) in Q0.32 and the ln product widths
    localparam int LN2_W = 32;
    localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam int LN_PROD_W = LOG2_W + LN2_W;
    localparam int LN_W      = LOG2_W;

    // Gain product and saturation compare widths
    localparam int PROD_W = GAIN_W + LN_W;
    localparam int MAG_W  = PROD_W - GAIN_FRAC - LOG_FRAC_BITS;
    localparam int CMP_W  = MAG_W + SAMPLE_WIDTH;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]       gain_t;

    // Payload handed from cell to cell
    typedef struct packed {
        logic [Y_W-1:0]    y;
        logic [LOG2_W-1:0] acc;
        logic              nonpos;
    } cell_data_t;

endpackage

// ===== rtl/core/slc_sample_if.sv =====
// Input stream channel: one signed sample per beat.
interface slc_sample_if;
    import slc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/slc_scaled_if.sv =====
// Output stream channel: one scaled result per beat.
interface slc_scaled_if;
    import slc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t scaled;

    modport source (output valid, output scaled, input ready);
    modport sink   (input valid, input scaled, output ready);
endinterface

// ===== rtl/core/slc_norm.sv =====
// Front end: magnitude, exponent search and mantissa normalization (two stages).
module slc_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  slc_pkg::sample_t   in_sample,
    output logic               out_valid,
    output slc_pkg::cell_data_t out_data
);
    import slc_pkg::*;

    localparam int WIDE_W = SAMPLE_WIDTH + Y_W - 1;

    logic [SAMPLE_WIDTH-1:0] u;
    logic [SAMPLE_WIDTH-1:0] abs_x;
    logic [SAMPLE_WIDTH-1:0] m_next;
    logic                    nonpos_next;
    logic [SAMPLE_WIDTH-1:0] m_reg;
    logic                    nonpos_reg;
    logic                    m_valid_reg;

    logic [E_W-1:0]          e;
    logic [WIDE_W-1:0]       wide;
    cell_data_t              data_next;
    cell_data_t              data_reg;
    logic                    valid_reg;

    // m = |x| + 1; zero and negative samples take the odd branch
    always_comb
    begin
        u           = in_sample;
        abs_x       = u[SAMPLE_WIDTH-1] ? (~u + SAMPLE_WIDTH'(1)) : u;
        m_next      = abs_x + SAMPLE_WIDTH'(1);
        nonpos_next = u[SAMPLE_WIDTH-1] || (u == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_reg      <= m_next;
            nonpos_reg <= nonpos_next;
        end
    end

    // Top set bit gives the integer log2; shift m into Q1.30
    always_comb
    begin
        e = '0;
        for (int i = 0; i < SAMPLE_WIDTH; i++)
        begin
            if (m_reg[i])
            begin
                e = E_W'(i);
            end
        end
        wide             = {m_reg, {(Y_W-1){1'b0}}} >> e;
        data_next.y      = wide[Y_W-1:0];
        data_next.acc    = LOG2_W'(e);
        data_next.nonpos = nonpos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/slc_cell.sv =====
// One squaring cell: produces one fraction bit of log2 per beat.
module slc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  slc_pkg::cell_data_t in_data,
    output logic                out_valid,
    output slc_pkg::cell_data_t out_data
);
    import slc_pkg::*;

    localparam int SQ_W = 2 * Y_W;

    logic [SQ_W-1:0] sq;
    logic [Y_W:0]    y2;
    logic            bit_out;
    cell_data_t      data_next;
    cell_data_t      data_reg;
    logic            valid_reg;

    // y = y*y >> 30; renormalize when it reaches 2.0 and shift the bit in
    always_comb
    begin
        sq               = SQ_W'(in_data.y) * SQ_W'(in_data.y);
        y2               = sq[SQ_W-1:Y_W-1];
        bit_out          = y2[Y_W];
        data_next.y      = bit_out ? y2[Y_W:1] : y2[Y_W-1:0];
        data_next.acc    = {in_data.acc[LOG2_W-2:0], bit_out};
        data_next.nonpos = in_data.nonpos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/slc_scale.sv =====
// Back end: log2 to ln, gain multiply, sign and saturation (three stages).
module slc_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  slc_pkg::gain_t      gain,
    input  logic                in_valid,
    input  slc_pkg::cell_data_t in_data,
    output logic                out_valid,
    output slc_pkg::sample_t    out_scaled
);
    import slc_pkg::*;

    localparam logic [LN_PROD_W-1:0] ROUND_HALF = LN_PROD_W'(1) << (LN2_W - 1);
    localparam logic [CMP_W-1:0] LIM_POS = (CMP_W'(1) << (SAMPLE_WIDTH - 1)) - CMP_W'(1);
    localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(1) << (SAMPLE_WIDTH - 1);

    // Stage A
    logic [LN_PROD_W-1:0] ln_full;
    logic [LN_W-1:0]      ln_reg;
    logic                 nonpos_a_reg;
    logic                 valid_a_reg;

    // Stage B
    logic [GAIN_W-1:0]    g_bits;
    logic [GAIN_W-1:0]    gabs;
    logic                 g_neg;
    logic [PROD_W-1:0]    prod;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic                 valid_b_reg;

    // Stage C
    logic [CMP_W-1:0]     mag_ext;
    logic [CMP_W-1:0]     sat;
    logic                 neg_eff;
    logic [SAMPLE_WIDTH-1:0] scaled_next;
    logic [SAMPLE_WIDTH-1:0] scaled_reg;
    logic                 valid_c_reg;

    // ln = round(log2 * ln2)
    assign ln_full = LN_PROD_W'(in_data.acc) * LN_PROD_W'(LN2_Q32) + ROUND_HALF;

    // |gain| * ln, truncated to an integer magnitude
    always_comb
    begin
        g_bits = gain;
        g_neg  = g_bits[GAIN_W-1];
        gabs   = g_neg ? (~g_bits + GAIN_W'(1)) : g_bits;
        prod   = PROD_W'(gabs) * PROD_W'(ln_reg);
    end

    // Negative zero collapses to zero; clamp to the sample range
    always_comb
    begin
        mag_ext = CMP_W'(mag_reg);
        neg_eff = neg_reg && (mag_reg != '0);
        if (neg_eff)
        begin
            sat = (mag_ext > LIM_NEG) ? LIM_NEG : mag_ext;
        end
        else
        begin
            sat = (mag_ext > LIM_POS) ? LIM_POS : mag_ext;
        end
        scaled_next = neg_eff ? (~sat[SAMPLE_WIDTH-1:0] + SAMPLE_WIDTH'(1))
                              : sat[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ln_reg       <= ln_full[LN2_W +: LN_W];
            nonpos_a_reg <= in_data.nonpos;
            mag_reg      <= prod[PROD_W-1 -: MAG_W];
            neg_reg      <= g_neg != nonpos_a_reg;
            scaled_reg   <= scaled_next;
        end
    end

    assign out_valid  = valid_c_reg;
    assign out_scaled = scaled_reg;

endmodule

// ===== rtl/core/signed_log_compander.sv =====
// Top level of the signed logarithmic compander.
//
// Usage:
//   pixel  : input stream, one signed sample per beat (valid/ready).
//   result : output stream, one signed scaled value per beat, in order.
//   gain_we/gain_wdata : writes the signed Q8.8 gain; write only while no
//            beat is in flight. Reset value is 10.0.
// Positive x gives gain*ln(x+1); zero or negative x gives -gain*ln(1-x),
// truncated toward zero and saturated to the sample range.
// Pipeline: 2 front-end stages, one squaring cell per log2 fraction
// bit, 3 back-end stages. Throughput: one beat per cycle unless stalled;
// each cell squares one item per cycle unless stalled.
// Reset: all pipeline valids clear, gain returns to 10.0, ready is high.
// Stall: when a result waits and result.ready is low, the whole pipeline
// holds and pixel.ready drops the same cycle; nothing is lost or repeated.
module signed_log_compander (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                gain_we,
    input  slc_pkg::gain_t      gain_wdata,
    slc_sample_if.sink          pixel,
    slc_scaled_if.source        result
);
    import slc_pkg::*;

    logic       advance;
    gain_t      gain_reg;
    logic       cell_valid [0:LOG_FRAC_BITS];
    cell_data_t cell_data  [0:LOG_FRAC_BITS];
    logic       scale_valid;
    sample_t    scale_out;

    // Whole pipeline moves unless the output register is full and blocked
    assign advance     = !result.valid || result.ready;
    assign pixel.ready = advance;

    // Gain register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= gain_t'(GAIN_RESET);
        end
        else if (gain_we)
        begin
            gain_reg <= gain_wdata;
        end
    end

    slc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (pixel.valid),
        .in_sample (pixel.sample),
        .out_valid (cell_valid[0]),
        .out_data  (cell_data[0])
    );

    // Row of squaring cells, one per fraction bit
    for (genvar i = 0; i < LOG_FRAC_BITS; i++)
    begin : g_cell
        slc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    slc_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .gain       (gain_reg),
        .in_valid   (cell_valid[LOG_FRAC_BITS]),
        .in_data    (cell_data[LOG_FRAC_BITS]),
        .out_valid  (scale_valid),
        .out_scaled (scale_out)
    );

    assign result.valid  = scale_valid;
    assign result.scaled = scale_out;

`ifndef SYNTH
    // A blocked result must stop intake
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !pixel.ready)
        else $error("input accepted while result is blocked");

    // The last cell of the row holds its output while the pipeline is held
    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cell_valid[LOG_FRAC_BITS])
                     && $stable(cell_data[LOG_FRAC_BITS]))
        else $error("cell row moved during a stall");

    // Normalized mantissa always lies in [1, 2)
    a_mantissa_norm: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0] |-> cell_data[0].y[Y_W-1])
        else $error("mantissa not normalized");
`endif

endmodule

// ===== sim/tb_signed_log_compander.sv =====
// Self-checking testbench for signed_log_compander: directed and random sample streams.
`timescale 1ns / 100ps

module tb_signed_log_compander;
    import slc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_REPORTS = 10;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    typedef struct {
        sample_t sample;
        gain_t   gain;
        sample_t scaled;
    } scaled_beat_t;

    logic  clk;
    logic  rst_n;
    logic  gain_we;
    gain_t gain_wdata;

    slc_sample_if pix_if ();
    slc_scaled_if res_if ();

    signed_log_compander dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .gain_we    (gain_we),
        .gain_wdata (gain_wdata),
        .pixel      (pix_if),
        .result     (res_if)
    );

    scaled_beat_t scaled_pending[$];
    gain_t        gain_model;
    int           error_count;
    int           mismatch_count;
    int           samples_sent;
    int           results_seen;
    int           gains_used;
    int           cycle_count;
    int           burst_left;
    int           gap_max;
    int           stall_mode;
    int           stall_phase;

    // Clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, scaled_pending.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Odd-symmetric log scaling: +/- gain * ln(|x| + 1), truncated, saturated
    function automatic sample_t log_scale(sample_t x, gain_t g);
        longint      xi;
        logic [63:0] mag_x;
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] log2_q;
        logic [63:0] ln_q;
        logic [63:0] gabs;
        logic [63:0] mag;
        logic [63:0] lim_pos;
        logic [63:0] lim_neg;
        int          e;
        bit          nonpos;
        bit          gneg;
        bit          neg;
        xi      = x;
        nonpos  = (xi <= 0);
        mag_x   = (xi < 0) ? 64'(-xi) : 64'(xi);
        m       = mag_x + 64'd1;
        e       = 0;
        t       = m;
        while (t > 64'd1)
        begin
            t = t >> 1;
            e++;
        end
        y = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
        // one fraction bit per squaring, MSB first
        frac = '0;
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31))
            begin
                y    = y >> 1;
                frac = frac | 64'd1;
            end
        end
        log2_q  = (64'(e) << LOG_FRAC_BITS) | frac;
        ln_q    = (log2_q * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
        gneg    = g[GAIN_W-1];
        gabs    = gneg ? 64'(-longint'(g)) : 64'(longint'(g));
        mag     = (gabs * ln_q) >> (GAIN_FRAC + LOG_FRAC_BITS);
        neg     = (gneg != nonpos) && (mag != 0);
        lim_pos = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
        lim_neg = 64'd1 << (SAMPLE_WIDTH - 1);
        if (neg)
        begin
            if (mag > lim_neg)
                mag = lim_neg;
            return sample_t'(-longint'(mag));
        end
        if (mag > lim_pos)
            mag = lim_pos;
        return sample_t'(mag);
    endfunction

    // Receiver ready pattern
    always @(negedge clk)
    begin
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     res_if.ready = 1'b1;
            STALL_RANDOM:   res_if.ready = ($urandom_range(0, 99) >= 30);
            STALL_PERIODIC: res_if.ready = ((stall_phase % 11) >= 4);
            STALL_HEAVY:    res_if.ready = ($urandom_range(0, 99) < 25);
            default:        res_if.ready = 1'b1;
        endcase
    end

    task automatic note_error(input string what);
        error_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    // Result checker: every output beat against the oldest prediction
    always @(posedge clk)
    begin
        scaled_beat_t exp_beat;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (scaled_pending.size() == 0)
                note_error($sformatf("unexpected result beat scaled=%0d", res_if.scaled));
            else
            begin
                exp_beat = scaled_pending.pop_front();
                if (res_if.scaled !== exp_beat.scaled)
                    note_error($sformatf("sample=%0d gain=%0d expected %0d got %0d",
                                         exp_beat.sample, exp_beat.gain,
                                         exp_beat.scaled, res_if.scaled));
            end
        end
    end

    // Send one sample beat; the sender works in bursts with random gaps
    task automatic send_sample(input sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                pix_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        pix_if.valid  = 1'b1;
        pix_if.sample = s;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        scaled_pending.push_back('{s, gain_model, log_scale(s, gain_model)});
        samples_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Wait until every predicted result has come back
    task automatic wait_idle();
        pix_if.valid = 1'b0;
        burst_left   = 0;
        while (scaled_pending.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Gain write, only with the pipeline empty
    task automatic write_gain(input gain_t g);
        wait_idle();
        gain_we    = 1'b1;
        gain_wdata = g;
        @(posedge clk);
        gain_model = g;
        gains_used++;
        @(negedge clk);
        gain_we = 1'b0;
    endtask

    function automatic sample_t pick_sample();
        int     k;
        longint v;
        case ($urandom_range(0, 7))
            0, 1, 2: return sample_t'($urandom());
            3:       return sample_t'($signed($urandom_range(0, 128)) - 64);
            4, 5:
            begin
                // around mantissa boundaries: 2^k - 1, 2^k, 2^k + 1
                k = $urandom_range(0, SAMPLE_WIDTH - 2);
                v = (longint'(1) << k) + $signed($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
                return sample_t'(v);
            end
            6:
            begin
                case ($urandom_range(0, 2))
                    0:       return sample_t'(longint'(1) << (SAMPLE_WIDTH - 1));
                    1:       return sample_t'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
                    default: return sample_t'(1 - (longint'(1) << (SAMPLE_WIDTH - 1)));
                endcase
            end
            default: return sample_t'(0);
        endcase
    endfunction

    // Reset gain: zero, unit steps, both range ends
    task automatic test_reset_gain();
        send_sample(sample_t'(0));
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(2));
        send_sample(sample_t'(-2));
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-32768));
        send_sample(sample_t'(-32767));
        send_sample(sample_t'(100));
    endtask

    // Gain extremes, zero gain, and magnitudes that truncate to zero
    task automatic test_gain_extremes();
        write_gain(gain_t'(-32768));
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-32768));
        send_sample(sample_t'(1));
        write_gain(gain_t'(32767));
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-1));
        write_gain(gain_t'(0));
        send_sample(sample_t'(5));
        send_sample(sample_t'(-5));
        // tiny gains: negative sign with zero magnitude must give 0
        write_gain(gain_t'(1));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(32767));
        write_gain(gain_t'(-1));
        send_sample(sample_t'(5));
        send_sample(sample_t'(-32768));
        write_gain(gain_t'(256));
        send_sample(sample_t'(0));
        send_sample(sample_t'(255));
    endtask

    // Random streams under varied gains, gaps and receiver stalls
    task automatic test_random_streams();
        gain_t g;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       g = gain_t'(32767);
                1:       g = gain_t'(-32768);
                2:       g = GAIN_RESET;
                3:       g = gain_t'(-256);
                default: g = gain_t'($urandom());
            endcase
            write_gain(g);
            stall_mode = phase % 4;
            gap_max    = (phase == 2 || phase == 6) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        gain_we        = 1'b0;
        gain_wdata     = '0;
        pix_if.valid   = 1'b0;
        pix_if.sample  = '0;
        res_if.ready   = 1'b0;
        gain_model     = GAIN_RESET;
        error_count    = 0;
        mismatch_count = 0;
        samples_sent   = 0;
        results_seen   = 0;
        gains_used     = 1;
        cycle_count    = 0;
        burst_left     = 0;
        gap_max        = 3;
        stall_mode     = STALL_RANDOM;
        stall_phase    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_gain();
        test_gain_extremes();
        test_random_streams();

        // drain, then watch for stray beats
        wait_idle();
        repeat (40) @(posedge clk);
        if (scaled_pending.size() != 0)
        begin
            error_count++;
            $display("ERROR: %0d predicted results never arrived", scaled_pending.size());
        end

        $display("Sent %0d samples under %0d gain settings, checked %0d results",
                 samples_sent, gains_used, results_seen);
        $display("Mismatches: %0d, with burst gaps and four receiver stall patterns",
                 mismatch_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
